>>> sv/morse_character_keyer_core_assert.svh
`ifndef MORSE_CHARACTER_KEYER_CORE_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mck_pkg.sv
`timescale 1ns / 1ps
package mck_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 4;

  localparam logic [2:0] REG_DOT        = 3'd0;
  localparam logic [2:0] REG_DASH       = 3'd1;
  localparam logic [2:0] REG_SYMBOL_GAP = 3'd2;
  localparam logic [2:0] REG_LETTER_GAP = 3'd3;
  localparam logic [2:0] REG_WORD_GAP   = 3'd4;

  typedef enum logic [1:0] {
    CHAR_NONE,
    CHAR_SYMBOLS,
    CHAR_SPACE
  } char_kind_t;

  typedef enum logic [1:0] {
    SEG_MARK,
    SEG_SYMBOL_GAP,
    SEG_LETTER_GAP,
    SEG_WORD_GAP
  } seg_kind_t;

  typedef struct packed {
    logic      load;
    logic      shift;
    logic      emit;
    seg_kind_t seg;
  } ctrl_cmd_t;

  typedef struct packed {
    char_kind_t kind;
    logic       last_sym;
  } dp_status_t;

  typedef struct packed {
    char_kind_t kind;
    logic [4:0] bits;
    logic [2:0] count;
  } char_code_t;

  localparam logic [3:0] LETTER_BITS [0:25] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  localparam logic [2:0] LETTER_LEN [0:25] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [4:0] DIGIT_BITS [0:9] = '{
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  function automatic char_code_t decode_char(input logic [7:0] c);
    char_code_t r;
    logic [7:0] off;
    r.kind  = CHAR_NONE;
    r.bits  = '0;
    r.count = '0;
    off     = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      off     = c - 8'h61;
      r.kind  = CHAR_SYMBOLS;
      r.bits  = {1'b0, LETTER_BITS[off[4:0]]};
      r.count = LETTER_LEN[off[4:0]];
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      off     = c - 8'h41;
      r.kind  = CHAR_SYMBOLS;
      r.bits  = {1'b0, LETTER_BITS[off[4:0]]};
      r.count = LETTER_LEN[off[4:0]];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off     = c - 8'h30;
      r.kind  = CHAR_SYMBOLS;
      r.bits  = DIGIT_BITS[off[3:0]];
      r.count = 3'd5;
    end else if (c == 8'h20) begin
      r.kind = CHAR_SPACE;
    end
    return r;
  endfunction

endpackage

>>> sv/mck_ctrl.sv
`timescale 1ns / 1ps
module mck_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  mck_pkg::dp_status_t    status,
  output mck_pkg::ctrl_cmd_t     cmd,
  output logic                   busy
);
  import mck_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM_ON,
    ST_SYM_GAP,
    ST_LETTER_GAP,
    ST_WORD_GAP
  } state_t;

  state_t    state;
  state_t    state_next;
  logic      emit;
  seg_kind_t seg;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (status.kind)
            CHAR_SYMBOLS: state_next = ST_SYM_ON;
            CHAR_SPACE:   state_next = ST_WORD_GAP;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_SYM_ON:  state_next = ST_SYM_GAP;
      ST_SYM_GAP: state_next = status.last_sym ? ST_LETTER_GAP : ST_SYM_ON;
      ST_LETTER_GAP, ST_WORD_GAP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      emit  <= 1'b0;
      seg   <= SEG_MARK;
    end else begin
      state <= state_next;
      emit  <= (state_next != ST_IDLE);
      unique case (state_next)
        ST_SYM_ON:     seg <= SEG_MARK;
        ST_SYM_GAP:    seg <= SEG_SYMBOL_GAP;
        ST_LETTER_GAP: seg <= SEG_LETTER_GAP;
        ST_WORD_GAP:   seg <= SEG_WORD_GAP;
        default:       seg <= SEG_MARK;
      endcase
    end
  end

  assign cmd.load  = (state == ST_IDLE) && start;
  assign cmd.shift = (state == ST_SYM_GAP);
  assign cmd.emit  = emit;
  assign cmd.seg   = seg;
  assign busy      = (state != ST_IDLE);

`include "morse_character_keyer_core_assert.svh"

  `MCK_ASSERT_NOW(a_emit_tracks_state, 1'b1, emit == (state != ST_IDLE), "strobe out of step with state")
  `MCK_ASSERT_NEXT(a_mark_then_gap, state == ST_SYM_ON, state == ST_SYM_GAP, "mark not followed by gap")
  `MCK_ASSERT_NEXT(a_last_sym_closes, (state == ST_SYM_GAP) && status.last_sym, state == ST_LETTER_GAP, "letter gap missed")
  `MCK_ASSERT_NEXT(a_end_to_idle, (state == ST_LETTER_GAP) || (state == ST_WORD_GAP), state == ST_IDLE, "character did not end")

endmodule

>>> sv/mck_datapath.sv
`timescale 1ns / 1ps
module mck_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mck_pkg::ctrl_cmd_t            cmd,
  input  logic [7:0]                    char_code,
  output mck_pkg::dp_status_t           status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mck_pkg::ADDR_W-1:0]    paddr,
  input  logic [mck_pkg::DATA_W-1:0]    pwdata,
  output logic [mck_pkg::DATA_W-1:0]    prdata,
  output logic                          strobe,
  output logic                          key_on,
  output logic [mck_pkg::LEN_W-1:0]     length_units,
  output logic                          last_segment
);
  import mck_pkg::*;

  logic [LEN_W-1:0] dot_units;
  logic [LEN_W-1:0] dash_units;
  logic [LEN_W-1:0] symbol_gap_units;
  logic [LEN_W-1:0] letter_gap_units;
  logic [LEN_W-1:0] word_gap_units;
  logic [4:0]       sym_bits;
  logic [2:0]       sym_count;
  logic             wr_en;
  logic [2:0]       reg_idx;
  char_code_t       code;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign code    = decode_char(char_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_units        <= 4'd1;
      dash_units       <= 4'd3;
      symbol_gap_units <= 4'd1;
      letter_gap_units <= 4'd3;
      word_gap_units   <= 4'd7;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DOT:        dot_units        <= pwdata[LEN_W-1:0];
        REG_DASH:       dash_units       <= pwdata[LEN_W-1:0];
        REG_SYMBOL_GAP: symbol_gap_units <= pwdata[LEN_W-1:0];
        REG_LETTER_GAP: letter_gap_units <= pwdata[LEN_W-1:0];
        REG_WORD_GAP:   word_gap_units   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DOT:        prdata[LEN_W-1:0] = dot_units;
      REG_DASH:       prdata[LEN_W-1:0] = dash_units;
      REG_SYMBOL_GAP: prdata[LEN_W-1:0] = symbol_gap_units;
      REG_LETTER_GAP: prdata[LEN_W-1:0] = letter_gap_units;
      REG_WORD_GAP:   prdata[LEN_W-1:0] = word_gap_units;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_bits  <= code.bits;
      sym_count <= code.count;
    end else if (cmd.shift) begin
      sym_bits  <= {1'b0, sym_bits[4:1]};
      sym_count <= sym_count - 3'd1;
    end
  end

  assign status.kind     = code.kind;
  assign status.last_sym = (sym_count == 3'd1);

  always_comb begin
    case (cmd.seg)
      SEG_MARK:       length_units = sym_bits[0] ? dash_units : dot_units;
      SEG_SYMBOL_GAP: length_units = symbol_gap_units;
      SEG_LETTER_GAP: length_units = letter_gap_units;
      default:        length_units = word_gap_units;
    endcase
  end

  assign strobe       = cmd.emit;
  assign key_on       = (cmd.seg == SEG_MARK);
  assign last_segment = (cmd.seg == SEG_LETTER_GAP) || (cmd.seg == SEG_WORD_GAP);

endmodule

>>> sv/morse_character_keyer_core.sv
`timescale 1ns / 1ps
// A character is taken when start is high and busy is low, and its Morse keying
// leaves as one segment word per clock, each shown for exactly one cycle with
// strobe high; the receiver cannot stall, so it must take every word as it
// comes. A letter or digit of n symbols gives 2n+1 words in consecutive
// cycles (at most 11 for a digit), starting the cycle after acceptance, and a
// space gives one word; busy is high exactly while words are being sent, so the
// next character can be taken in the cycle after the last word. A character
// that is not recognized gives no words and busy never rises. The words come
// from the sequencer, which steps through one segment per clock.
module morse_character_keyer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    char_code,
  output logic                          strobe,
  output logic                          key_on,
  output logic [mck_pkg::LEN_W-1:0]     length_units,
  output logic                          last_segment,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mck_pkg::ADDR_W-1:0]    paddr,
  input  logic [mck_pkg::DATA_W-1:0]    pwdata,
  output logic [mck_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import mck_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  mck_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mck_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .char_code    (char_code),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .strobe       (strobe),
    .key_on       (key_on),
    .length_units (length_units),
    .last_segment (last_segment)
  );

endmodule
